### hdl/rmzyx_pkg.sv
// rmzyx_pkg: shared constants, types and the arctangent table for the
// rotation matrix to zyx euler core. No dependencies.
`timescale 1ns / 1ps
`default_nettype none
package rmzyx_pkg;

	localparam int CW               = 36;
	localparam int ACC_FRAC         = 24;
	localparam int GUARD_BITS       = 16;
	localparam int SQRT_STAGES      = 32;
	localparam int MAX_STEPS        = 32;
	localparam int ANGLE_FRAC_DEF   = 8;
	localparam int CORDIC_ITER_DEF  = 16;
	localparam int EPS_W            = 15;
	localparam logic [EPS_W-1:0] EPS_RESET = 15'd1;
	localparam logic signed [CW-1:0] DEG180_Q24 = 36'sd3019898880;

	typedef struct packed {
		logic signed [23:0] tx;
		logic signed [23:0] ty;
		logic signed [23:0] tz;
		logic signed [15:0] r00;
		logic signed [15:0] r10;
		logic signed [15:0] r20;
		logic signed [15:0] r21;
		logic signed [15:0] r22;
		logic signed [15:0] r11;
		logic signed [15:0] r12;
	} side_t;

	typedef struct packed {
		logic signed [23:0] tx;
		logic signed [23:0] ty;
		logic signed [23:0] tz;
		logic               lock;
	} tail_t;

	// atan(2^-i) in degrees * 2^24
	function automatic logic signed [CW-1:0] atan_q24(input int i);
		logic signed [CW-1:0] v;
		case (i)
			0: v = 36'sd754974720;
			1: v = 36'sd445687602;
			2: v = 36'sd235489088;
			3: v = 36'sd119537938;
			4: v = 36'sd60000934;
			5: v = 36'sd30029717;
			6: v = 36'sd15018523;
			7: v = 36'sd7509720;
			8: v = 36'sd3754917;
			9: v = 36'sd1877466;
			10: v = 36'sd938734;
			11: v = 36'sd469367;
			12: v = 36'sd234684;
			13: v = 36'sd117342;
			14: v = 36'sd58671;
			15: v = 36'sd29335;
			16: v = 36'sd14668;
			17: v = 36'sd7334;
			18: v = 36'sd3667;
			19: v = 36'sd1833;
			20: v = 36'sd917;
			21: v = 36'sd458;
			22: v = 36'sd229;
			23: v = 36'sd115;
			24: v = 36'sd57;
			25: v = 36'sd29;
			26: v = 36'sd14;
			27: v = 36'sd7;
			28: v = 36'sd4;
			29: v = 36'sd2;
			30: v = 36'sd1;
			default: v = '0;
		endcase
		return v;
	endfunction

endpackage
`default_nettype wire

### hdl/rotation_matrix_to_zyx_euler_core.sv
// Converts a pose (translation plus rotation entries in Q1.14) to zyx euler
// angles. A transform is taken every cycle: start is accepted whenever busy is
// low, and busy is always low. Each transform yields one result, shown for one
// cycle with done, after two multiply/add stages, 32 square root stages, an
// operand select stage, the cordic pipeline and an output rounding stage.
// Results cannot be held off. Depends on rmzyx_pkg, rmzyx_isqrt, rmzyx_cordic.
`timescale 1ns / 1ps
`default_nettype none
module rotation_matrix_to_zyx_euler_core import rmzyx_pkg::*; #(
	parameter int ANGLE_FRAC_BITS   = ANGLE_FRAC_DEF,
	parameter int CORDIC_ITERATIONS = CORDIC_ITER_DEF
) (
	input  wire logic                    clk,
	input  wire logic                    arst_n,
	input  wire logic                    start,
	output logic                         busy,
	input  wire logic                    cfg_we,
	input  wire logic [EPS_W-1:0]        cfg_data,
	input  wire logic signed [23:0]      trans_x,
	input  wire logic signed [23:0]      trans_y,
	input  wire logic signed [23:0]      trans_z,
	input  wire logic signed [15:0]      rot_00,
	input  wire logic signed [15:0]      rot_10,
	input  wire logic signed [15:0]      rot_20,
	input  wire logic signed [15:0]      rot_21,
	input  wire logic signed [15:0]      rot_22,
	input  wire logic signed [15:0]      rot_11,
	input  wire logic signed [15:0]      rot_12,
	output logic                         done,
	output logic signed [23:0]           pos_x,
	output logic signed [23:0]           pos_y,
	output logic signed [23:0]           pos_z,
	output logic signed [16:0]           angle_rx,
	output logic signed [15:0]           angle_ry,
	output logic signed [16:0]           angle_rz,
	output logic                         gimbal_lock
);

	localparam int STEPS = (CORDIC_ITERATIONS > MAX_STEPS) ? MAX_STEPS : CORDIC_ITERATIONS;
	localparam int SH    = ACC_FRAC - ANGLE_FRAC_BITS;
	localparam logic signed [CW-1:0] HALF   = CW'(64'd1 << (SH - 1));
	localparam logic signed [CW-1:0] LIM180 = CW'(180 * (2 ** ANGLE_FRAC_BITS));
	localparam logic signed [CW-1:0] LIM90  = CW'(90 * (2 ** ANGLE_FRAC_BITS));

	logic [EPS_W-1:0] eps_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			eps_q <= EPS_RESET;
		end else if (cfg_we) begin
			eps_q <= cfg_data;
		end
	end

	assign busy = 1'b0;

	// stage 1: squares
	logic        vld_s1, vld_s2;
	side_t       side_s1, side_s2;
	logic [31:0] sq0_s1, sq1_s1, sum_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
		end else begin
			vld_s1 <= start && !busy;
			vld_s2 <= vld_s1;
		end
	end

	always_ff @(posedge clk) begin
		side_s1 <= '{trans_x, trans_y, trans_z, rot_00, rot_10, rot_20,
			rot_21, rot_22, rot_11, rot_12};
		sq0_s1  <= 32'(rot_00 * rot_00);
		sq1_s1  <= 32'(rot_10 * rot_10);
		side_s2 <= side_s1;
		sum_s2  <= sq0_s1 + sq1_s1;
	end

	// square root and matching delay of the side data
	logic [31:0] root;
	side_t       side_d [0:SQRT_STAGES-1];
	logic        vld_d  [0:SQRT_STAGES-1];

	rmzyx_isqrt u_isqrt (
		.clk      (clk),
		.sum_in   (sum_s2),
		.root_out (root)
	);

	always_ff @(posedge clk) begin
		side_d[0] <= side_s2;
		for (int k = 1; k < SQRT_STAGES; k++) begin
			side_d[k] <= side_d[k-1];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int k = 0; k < SQRT_STAGES; k++) begin
				vld_d[k] <= 1'b0;
			end
		end else begin
			vld_d[0] <= vld_s2;
			for (int k = 1; k < SQRT_STAGES; k++) begin
				vld_d[k] <= vld_d[k-1];
			end
		end
	end

	// operand select
	side_t                sd;
	logic                 lock;
	logic                 vld_sel;
	tail_t                tail_sel;
	logic signed [CW-1:0] rx_x_sel, rx_y_sel, ry_x_sel, ry_y_sel, rz_x_sel, rz_y_sel;

	assign sd   = side_d[SQRT_STAGES-1];
	assign lock = root <= {1'b0, eps_q, 16'h0000};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_sel <= 1'b0;
		end else begin
			vld_sel <= vld_d[SQRT_STAGES-1];
		end
	end

	always_ff @(posedge clk) begin
		tail_sel <= '{sd.tx, sd.ty, sd.tz, lock};
		ry_x_sel <= CW'(root);
		ry_y_sel <= CW'(-(17'(sd.r20))) <<< GUARD_BITS;
		rz_x_sel <= CW'(sd.r00) <<< GUARD_BITS;
		rz_y_sel <= CW'(sd.r10) <<< GUARD_BITS;
		if (lock) begin
			rx_x_sel <= CW'(sd.r11) <<< GUARD_BITS;
			rx_y_sel <= CW'(-(17'(sd.r12))) <<< GUARD_BITS;
		end else begin
			rx_x_sel <= CW'(sd.r22) <<< GUARD_BITS;
			rx_y_sel <= CW'(sd.r21) <<< GUARD_BITS;
		end
	end

	// cordic pipelines
	logic signed [CW-1:0] zx, zy, zz;

	rmzyx_cordic #(.STEPS(STEPS)) u_cordic_rx (
		.clk (clk), .x_in (rx_x_sel), .y_in (rx_y_sel), .z_out (zx)
	);
	rmzyx_cordic #(.STEPS(STEPS)) u_cordic_ry (
		.clk (clk), .x_in (ry_x_sel), .y_in (ry_y_sel), .z_out (zy)
	);
	rmzyx_cordic #(.STEPS(STEPS)) u_cordic_rz (
		.clk (clk), .x_in (rz_x_sel), .y_in (rz_y_sel), .z_out (zz)
	);

	tail_t tail_c [0:STEPS];
	logic  vld_c  [0:STEPS];

	always_ff @(posedge clk) begin
		tail_c[0] <= tail_sel;
		for (int k = 1; k <= STEPS; k++) begin
			tail_c[k] <= tail_c[k-1];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int k = 0; k <= STEPS; k++) begin
				vld_c[k] <= 1'b0;
			end
		end else begin
			vld_c[0] <= vld_sel;
			for (int k = 1; k <= STEPS; k++) begin
				vld_c[k] <= vld_c[k-1];
			end
		end
	end

	// round half up and clamp
	function automatic logic signed [CW-1:0] round_clamp(
		input logic signed [CW-1:0] z,
		input logic signed [CW-1:0] lim
	);
		logic signed [CW-1:0] r;
		r = (z + HALF) >>> SH;
		if (r > lim) begin
			r = lim;
		end
		if (r < -lim) begin
			r = -lim;
		end
		return r;
	endfunction

	logic signed [CW-1:0] ax, ay, az;
	tail_t                tl;

	always_comb begin
		tl = tail_c[STEPS];
		ax = round_clamp(zx, LIM180);
		ay = round_clamp(zy, LIM90);
		az = tl.lock ? '0 : round_clamp(zz, LIM180);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done <= 1'b0;
		end else begin
			done <= vld_c[STEPS];
		end
	end

	always_ff @(posedge clk) begin
		pos_x       <= tl.tx;
		pos_y       <= tl.ty;
		pos_z       <= tl.tz;
		gimbal_lock <= tl.lock;
		angle_rx    <= ax[16:0];
		angle_ry    <= ay[15:0];
		angle_rz    <= az[16:0];
	end

endmodule
`default_nettype wire

### hdl/rmzyx_isqrt.sv
// rmzyx_isqrt: pipelined digit-by-digit square root of sum * 2^32,
// one result bit per stage. Depends on rmzyx_pkg.
`timescale 1ns / 1ps
`default_nettype none
module rmzyx_isqrt import rmzyx_pkg::*; (
	input  wire logic        clk,
	input  wire logic [31:0] sum_in,
	output logic      [31:0] root_out
);

	logic [CW-1:0] rem_s  [0:SQRT_STAGES];
	logic [31:0]   root_s [0:SQRT_STAGES];
	logic [31:0]   src_s  [0:SQRT_STAGES];

	assign rem_s[0]  = '0;
	assign root_s[0] = '0;
	assign src_s[0]  = sum_in;

	for (genvar k = 0; k < SQRT_STAGES; k++) begin : g_stage
		logic [CW-1:0] rem2;
		logic [CW-1:0] trial;
		assign rem2  = {rem_s[k][CW-3:0], src_s[k][31:30]};
		assign trial = {2'b00, root_s[k], 2'b01};
		always_ff @(posedge clk) begin
			src_s[k+1] <= {src_s[k][29:0], 2'b00};
			if (rem2 >= trial) begin
				rem_s[k+1]  <= rem2 - trial;
				root_s[k+1] <= {root_s[k][30:0], 1'b1};
			end else begin
				rem_s[k+1]  <= rem2;
				root_s[k+1] <= {root_s[k][30:0], 1'b0};
			end
		end
	end

	assign root_out = root_s[SQRT_STAGES];

endmodule
`default_nettype wire

### hdl/rmzyx_cordic.sv
// rmzyx_cordic: pipelined vectoring cordic atan2, degrees * 2^24,
// one pre-rotation stage then one stage per step. Depends on rmzyx_pkg.
`timescale 1ns / 1ps
`default_nettype none
module rmzyx_cordic import rmzyx_pkg::*; #(
	parameter int STEPS = CORDIC_ITER_DEF
) (
	input  wire logic                 clk,
	input  wire logic signed [CW-1:0] x_in,
	input  wire logic signed [CW-1:0] y_in,
	output logic signed [CW-1:0]      z_out
);

	logic signed [CW-1:0] x_s [0:STEPS];
	logic signed [CW-1:0] y_s [0:STEPS];
	logic signed [CW-1:0] z_s [0:STEPS];
	logic                 zero_s [0:STEPS];

	always_ff @(posedge clk) begin
		zero_s[0] <= (x_in == '0) && (y_in == '0);
		if (x_in[CW-1]) begin
			x_s[0] <= -x_in;
			y_s[0] <= -y_in;
			z_s[0] <= y_in[CW-1] ? -DEG180_Q24 : DEG180_Q24;
		end else begin
			x_s[0] <= x_in;
			y_s[0] <= y_in;
			z_s[0] <= '0;
		end
	end

	for (genvar i = 0; i < STEPS; i++) begin : g_step
		always_ff @(posedge clk) begin
			zero_s[i+1] <= zero_s[i];
			if (!y_s[i][CW-1]) begin
				x_s[i+1] <= x_s[i] + (y_s[i] >>> i);
				y_s[i+1] <= y_s[i] - (x_s[i] >>> i);
				z_s[i+1] <= z_s[i] + atan_q24(i);
			end else begin
				x_s[i+1] <= x_s[i] - (y_s[i] >>> i);
				y_s[i+1] <= y_s[i] + (x_s[i] >>> i);
				z_s[i+1] <= z_s[i] - atan_q24(i);
			end
		end
	end

	assign z_out = zero_s[STEPS] ? '0 : z_s[STEPS];

endmodule
`default_nettype wire
